// ----- rtl/hse_pkg.sv -----
package hse_pkg;

    localparam int KEY_W    = 8;
    localparam int HANDLE_W = 16;
    localparam int ENTRY_W  = KEY_W + HANDLE_W;

    // One input request
    typedef struct packed {
        logic signed [KEY_W-1:0] sort_key;
        logic [HANDLE_W-1:0]     handle;
        logic                    last_item;
    } item_t;

    // One sorted result
    typedef struct packed {
        logic signed [KEY_W-1:0] sorted_key;
        logic [HANDLE_W-1:0]     sorted_handle;
        logic                    run_end;
        logic                    overflowed;
    } result_t;

    // Stored entry
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [HANDLE_W-1:0]     handle;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_B_RD,
        S_B_HOLD,
        S_CHK,
        S_LEFT,
        S_RIGHT,
        S_CMP,
        S_X_CHK,
        S_X_RDE,
        S_X_SWAP,
        S_OUT,
        S_FLUSH
    } ctl_state_t;

    // Memory read address source
    typedef enum logic [2:0] {
        RD_BUILD,
        RD_LEFT,
        RD_RIGHT,
        RD_ROOT,
        RD_EXT,
        RD_OUT
    } rd_sel_t;

    // Memory write source
    typedef enum logic [2:0] {
        WR_NONE,
        WR_LOAD,
        WR_SWAP,
        WR_CHILD,
        WR_HOLD
    } wr_sel_t;

    typedef struct packed {
        logic    load;
        logic    init_build;
        logic    dec_build;
        logic    init_ext;
        logic    dec_ext;
        logic    init_out;
        logic    adv_out;
        logic    emit;
        logic    clear_set;
        logic    take_hold_build;
        logic    take_root;
        logic    take_swap;
        logic    take_left;
        logic    pick_right;
        logic    move_down;
        rd_sel_t rd_sel;
        wr_sel_t wr_sel;
    } cmd_t;

    typedef struct packed {
        logic has_left;
        logic has_right;
        logic hold_loses;
        logic b_zero;
        logic e_zero;
        logic out_last;
    } status_t;

endpackage

// ----- rtl/hse_ram.sv -----
module hse_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                                         clk,
    input  logic                                         wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                             wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                             rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- rtl/hse_datapath.sv -----
module hse_datapath #(
    parameter int MAX_ITEMS = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  hse_pkg::item_t   item,
    input  hse_pkg::cmd_t    cmd,
    output hse_pkg::status_t status,
    output hse_pkg::result_t result,
    output logic             result_valid
);

    localparam int ADDR_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int IDX_W  = ADDR_W + 1;

    logic [IDX_W-1:0]  count_reg;
    logic              ovf_reg;
    logic [IDX_W-1:0]  n_reg;
    logic [IDX_W-1:0]  len_reg;
    logic [ADDR_W-1:0] b_reg;
    logic [ADDR_W-1:0] e_reg;
    logic [ADDR_W-1:0] k_reg;
    logic [ADDR_W-1:0] i_reg;
    logic [ADDR_W-1:0] cidx_reg;
    logic              emit_reg;
    logic              last_reg;

    hse_pkg::entry_t   hold_reg;
    hse_pkg::entry_t   child_reg;
    hse_pkg::entry_t   tmp_reg;

    logic                        full;
    logic                        load_ok;
    logic [IDX_W-1:0]            count_after;
    logic [IDX_W-1:0]            l_idx;
    logic [IDX_W:0]              r_idx;
    logic [IDX_W-1:0]            n_last;
    logic                        right_wins;

    logic                        wr_en;
    logic [ADDR_W-1:0]           wr_addr;
    logic [hse_pkg::ENTRY_W-1:0] wr_data;
    logic [ADDR_W-1:0]           rd_addr;
    logic [hse_pkg::ENTRY_W-1:0] rd_data;
    hse_pkg::entry_t             rd_entry;
    hse_pkg::entry_t             in_entry;

    assign full        = (count_reg == IDX_W'(MAX_ITEMS));
    assign load_ok     = cmd.load && !full;
    assign count_after = count_reg + IDX_W'(load_ok);

    // Child indexes of the current sift position
    assign l_idx  = {i_reg, 1'b1};
    assign r_idx  = {({1'b0, i_reg} + {{ADDR_W{1'b0}}, 1'b1}), 1'b0};
    assign n_last = n_reg - {{(IDX_W-1){1'b0}}, 1'b1};

    assign rd_entry        = hse_pkg::entry_t'(rd_data);
    assign in_entry.key    = item.sort_key;
    assign in_entry.handle = item.handle;

    assign right_wins = ($signed(child_reg.key) < $signed(rd_entry.key));

    // Status back to the controller
    assign status.has_left   = (l_idx < len_reg);
    assign status.has_right  = (r_idx < {1'b0, len_reg});
    assign status.hold_loses = ($signed(hold_reg.key) < $signed(child_reg.key));
    assign status.b_zero     = (b_reg == '0);
    assign status.e_zero     = (e_reg == '0);
    assign status.out_last   = ({1'b0, k_reg} == n_last);

    // Select read address
    always_comb
    begin
        case (cmd.rd_sel)
            hse_pkg::RD_BUILD: rd_addr = b_reg;
            hse_pkg::RD_LEFT:  rd_addr = l_idx[ADDR_W-1:0];
            hse_pkg::RD_RIGHT: rd_addr = r_idx[ADDR_W-1:0];
            hse_pkg::RD_ROOT:  rd_addr = '0;
            hse_pkg::RD_EXT:   rd_addr = e_reg;
            hse_pkg::RD_OUT:   rd_addr = k_reg;
            default:           rd_addr = '0;
        endcase
    end

    // Select write address and data
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = i_reg;
        wr_data = hold_reg;
        case (cmd.wr_sel)
            hse_pkg::WR_LOAD:
            begin
                wr_en   = load_ok;
                wr_addr = count_reg[ADDR_W-1:0];
                wr_data = in_entry;
            end
            hse_pkg::WR_SWAP:
            begin
                wr_en   = 1'b1;
                wr_addr = e_reg;
                wr_data = tmp_reg;
            end
            hse_pkg::WR_CHILD:
            begin
                wr_en   = 1'b1;
                wr_data = child_reg;
            end
            hse_pkg::WR_HOLD:
            begin
                wr_en   = 1'b1;
                wr_data = hold_reg;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    hse_ram #(
        .WIDTH (hse_pkg::ENTRY_W),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Track set size, overflow and the sort indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            n_reg     <= '0;
            len_reg   <= '0;
            b_reg     <= '0;
            e_reg     <= '0;
            k_reg     <= '0;
            i_reg     <= '0;
            cidx_reg  <= '0;
            emit_reg  <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            emit_reg <= cmd.emit;
            last_reg <= cmd.emit && status.out_last;
            if (cmd.load)
            begin
                count_reg <= count_after;
                if (full)
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.clear_set)
            begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            if (cmd.init_build)
            begin
                n_reg <= count_after;
                b_reg <= count_after[IDX_W-1:1];
            end
            if (cmd.dec_build)
            begin
                b_reg <= b_reg - ADDR_W'(1);
            end
            if (cmd.init_ext)
            begin
                e_reg <= n_last[ADDR_W-1:0];
            end
            if (cmd.dec_ext)
            begin
                e_reg <= e_reg - ADDR_W'(1);
            end
            if (cmd.init_out)
            begin
                k_reg <= '0;
            end
            if (cmd.adv_out)
            begin
                k_reg <= k_reg + ADDR_W'(1);
            end
            if (cmd.take_hold_build)
            begin
                i_reg   <= b_reg;
                len_reg <= n_reg;
            end
            if (cmd.take_swap)
            begin
                i_reg   <= '0;
                len_reg <= {1'b0, e_reg};
            end
            if (cmd.take_left)
            begin
                cidx_reg <= l_idx[ADDR_W-1:0];
            end
            if (cmd.pick_right && right_wins)
            begin
                cidx_reg <= r_idx[ADDR_W-1:0];
            end
            if (cmd.move_down)
            begin
                i_reg <= cidx_reg;
            end
        end
    end

    // Hold the sifted entry, the larger child and the swapped-out root
    always_ff @(posedge clk)
    begin
        if (cmd.take_hold_build || cmd.take_swap)
        begin
            hold_reg <= rd_entry;
        end
        if (cmd.take_root)
        begin
            tmp_reg <= rd_entry;
        end
        if (cmd.take_left || (cmd.pick_right && right_wins))
        begin
            child_reg <= rd_entry;
        end
    end

    // Drive the result from the registered memory read
    assign result_valid         = emit_reg;
    assign result.sorted_key    = rd_entry.key;
    assign result.sorted_handle = rd_entry.handle;
    assign result.run_end       = last_reg;
    assign result.overflowed    = ovf_reg;

    // The set never grows past capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= IDX_W'(MAX_ITEMS))
        else $error("item count exceeds capacity");

    // A sift only descends into a child inside the heap
    a_move_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.move_down |-> ({1'b0, cidx_reg} < len_reg))
        else $error("sift moved outside the heap");

    // The last result of a run starts a fresh set
    a_run_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_reg && last_reg) |=> (count_reg == '0 && !ovf_reg))
        else $error("set not cleared after run end");

endmodule

// ----- rtl/hse_ctrl.sv -----
module hse_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             last_item,
    input  hse_pkg::status_t status,
    output hse_pkg::cmd_t    cmd,
    output logic             busy
);

    hse_pkg::ctl_state_t state_reg;
    hse_pkg::ctl_state_t state_next;
    logic                extract_reg;
    logic                extract_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= hse_pkg::S_IDLE;
            extract_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            extract_reg <= extract_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        extract_next = extract_reg;
        cmd          = '0;
        cmd.rd_sel   = hse_pkg::RD_OUT;
        cmd.wr_sel   = hse_pkg::WR_NONE;
        busy         = 1'b1;
        case (state_reg)
            hse_pkg::S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    cmd.wr_sel = hse_pkg::WR_LOAD;
                    if (last_item)
                    begin
                        cmd.init_build = 1'b1;
                        extract_next   = 1'b0;
                        state_next     = hse_pkg::S_B_RD;
                    end
                end
            end
            hse_pkg::S_B_RD:
            begin
                cmd.rd_sel = hse_pkg::RD_BUILD;
                state_next = hse_pkg::S_B_HOLD;
            end
            hse_pkg::S_B_HOLD:
            begin
                cmd.take_hold_build = 1'b1;
                state_next          = hse_pkg::S_CHK;
            end
            hse_pkg::S_CHK, hse_pkg::S_CMP:
            begin
                if (state_reg == hse_pkg::S_CHK && status.has_left)
                begin
                    cmd.rd_sel = hse_pkg::RD_LEFT;
                    state_next = hse_pkg::S_LEFT;
                end
                else if (state_reg == hse_pkg::S_CMP && status.hold_loses)
                begin
                    cmd.wr_sel    = hse_pkg::WR_CHILD;
                    cmd.move_down = 1'b1;
                    state_next    = hse_pkg::S_CHK;
                end
                else
                begin
                    // Place the held entry and finish this sift
                    cmd.wr_sel = hse_pkg::WR_HOLD;
                    if (!extract_reg)
                    begin
                        if (status.b_zero)
                        begin
                            cmd.init_ext = 1'b1;
                            extract_next = 1'b1;
                        end
                        else
                        begin
                            cmd.dec_build = 1'b1;
                        end
                        state_next = status.b_zero ? hse_pkg::S_X_CHK : hse_pkg::S_B_RD;
                    end
                    else
                    begin
                        cmd.dec_ext = 1'b1;
                        state_next  = hse_pkg::S_X_CHK;
                    end
                end
            end
            hse_pkg::S_LEFT:
            begin
                cmd.take_left = 1'b1;
                if (status.has_right)
                begin
                    cmd.rd_sel = hse_pkg::RD_RIGHT;
                    state_next = hse_pkg::S_RIGHT;
                end
                else
                begin
                    state_next = hse_pkg::S_CMP;
                end
            end
            hse_pkg::S_RIGHT:
            begin
                cmd.pick_right = 1'b1;
                state_next     = hse_pkg::S_CMP;
            end
            hse_pkg::S_X_CHK:
            begin
                if (status.e_zero)
                begin
                    cmd.init_out = 1'b1;
                    state_next   = hse_pkg::S_OUT;
                end
                else
                begin
                    cmd.rd_sel = hse_pkg::RD_ROOT;
                    state_next = hse_pkg::S_X_RDE;
                end
            end
            hse_pkg::S_X_RDE:
            begin
                cmd.take_root = 1'b1;
                cmd.rd_sel    = hse_pkg::RD_EXT;
                state_next    = hse_pkg::S_X_SWAP;
            end
            hse_pkg::S_X_SWAP:
            begin
                cmd.take_swap = 1'b1;
                cmd.wr_sel    = hse_pkg::WR_SWAP;
                state_next    = hse_pkg::S_CHK;
            end
            hse_pkg::S_OUT:
            begin
                cmd.rd_sel = hse_pkg::RD_OUT;
                cmd.emit   = 1'b1;
                if (status.out_last)
                begin
                    state_next = hse_pkg::S_FLUSH;
                end
                else
                begin
                    cmd.adv_out = 1'b1;
                end
            end
            hse_pkg::S_FLUSH:
            begin
                cmd.clear_set = 1'b1;
                state_next    = hse_pkg::S_IDLE;
            end
            default:
            begin
                state_next = hse_pkg::S_IDLE;
            end
        endcase
    end

    // Requests are only taken while idle
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (state_reg == hse_pkg::S_IDLE))
        else $error("load outside idle");

    // A sort always ends by clearing the set in the flush state before going idle
    a_flush_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hse_pkg::S_FLUSH) |=> (state_reg == hse_pkg::S_IDLE))
        else $error("flush did not return to idle");

    // A result is only emitted after the extraction phase
    a_emit_after_ext: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> extract_reg)
        else $error("emit before extraction");

endmodule

// ----- rtl/heap_sort_engine.sv -----
// Load: one cycle per request; busy stays low until the item marked last is taken.
// Sort: a build sift reads its entry (B_RD, B_HOLD), an extraction sift swaps the root
// out (X_CHK, X_RDE, X_SWAP); each level then runs CHK, LEFT, RIGHT (if a right child
// exists) and CMP, and the entry is placed where it stops; n/2 + n sifts in all.
// Output: one result per cycle on result_valid, the receiver cannot stall; busy drops
// the cycle after the last result. Reset (rst_n, async, low) clears count, flag and FSM.
module heap_sort_engine #(
    parameter int MAX_ITEMS = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  hse_pkg::item_t   item,
    output logic             busy,
    output hse_pkg::result_t result,
    output logic             result_valid
);

    hse_pkg::cmd_t    cmd;
    hse_pkg::status_t status;

    hse_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .last_item (item.last_item),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy)
    );

    hse_datapath #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

// ----- tb/heap_sort_engine_test.sv -----
`timescale 1ns / 1ps

// Track loaded sets and hold the sorted runs the engine must emit
class sort_scoreboard #(int CAPACITY = 64);
    hse_pkg::entry_t  held[CAPACITY];
    int unsigned      held_count;
    bit               dropped;
    hse_pkg::result_t pending[$];
    int unsigned      errors;

    function new();
        held_count = 0;
        dropped    = 0;
        errors     = 0;
    endfunction

    // Sift one entry down; move only toward a strictly larger child
    function void sift_down(int unsigned pos, int unsigned n);
        hse_pkg::entry_t hold;
        int unsigned     i;
        int unsigned     c;
        hold = held[pos];
        i    = pos;
        while (2 * i + 1 < n)
        begin
            c = 2 * i + 1;
            if (c != n - 1 && $signed(held[c].key) < $signed(held[c + 1].key))
                c = c + 1;
            if ($signed(hold.key) < $signed(held[c].key))
            begin
                held[i] = held[c];
                i       = c;
            end
            else
            begin
                break;
            end
        end
        held[i] = hold;
    endfunction

    // Build the max-heap, then pull the root to the back one slot at a time
    function void sort_held(int unsigned n);
        hse_pkg::entry_t t;
        for (int i = n / 2; i >= 0; i--)
            sift_down(i, n);
        for (int i = n - 1; i > 0; i--)
        begin
            t       = held[0];
            held[0] = held[i];
            held[i] = t;
            sift_down(0, i);
        end
    endfunction

    // Store an accepted request; on the last one queue the whole sorted run
    function void note_request(hse_pkg::item_t req);
        hse_pkg::result_t r;
        int unsigned      n;
        if (held_count < CAPACITY)
        begin
            held[held_count].key    = req.sort_key;
            held[held_count].handle = req.handle;
            held_count++;
        end
        else
        begin
            dropped = 1'b1;
        end
        if (!req.last_item)
            return;
        n = held_count;
        sort_held(n);
        for (int unsigned k = 0; k < n; k++)
        begin
            r.sorted_key    = held[k].key;
            r.sorted_handle = held[k].handle;
            r.run_end       = (k + 1 == n);
            r.overflowed    = dropped;
            pending.push_back(r);
        end
        held_count = 0;
        dropped    = 1'b0;
    endfunction

    function void report(string field, int want, int got);
        errors++;
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
    endfunction

    // Compare a strobed result against the oldest sorted entry
    function void check_result(hse_pkg::result_t got);
        hse_pkg::result_t want;
        if (pending.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected result: expected none, got key %0d handle %0d",
                     $time, $signed(got.sorted_key), got.sorted_handle);
            return;
        end
        want = pending.pop_front();
        if (got.sorted_key !== want.sorted_key)
            report("sorted_key", int'(want.sorted_key), int'(got.sorted_key));
        if (got.sorted_handle !== want.sorted_handle)
            report("sorted_handle", int'(want.sorted_handle), int'(got.sorted_handle));
        if (got.run_end !== want.run_end)
            report("run_end", int'(want.run_end), int'(got.run_end));
        if (got.overflowed !== want.overflowed)
            report("overflowed", int'(want.overflowed), int'(got.overflowed));
    endfunction
endclass

module heap_sort_engine_test;

    localparam int CAPACITY    = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEM_TARGET = 300;
    localparam int KEY_W       = hse_pkg::KEY_W;
    localparam int HANDLE_W    = hse_pkg::HANDLE_W;

    typedef enum {
        KEYS_ANY,
        KEYS_TIED,
        KEYS_EDGE
    } key_mix_t;

    logic             clk;
    logic             rst_n;
    logic             start;
    hse_pkg::item_t   item;
    logic             busy;
    hse_pkg::result_t result;
    logic             result_valid;

    sort_scoreboard #(CAPACITY) sb;
    int cycle_count = 0;
    int burst_left  = 0;
    int items_sent  = 0;

    heap_sort_engine #(
        .MAX_ITEMS(CAPACITY)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (item),
        .busy         (busy),
        .result       (result),
        .result_valid (result_valid)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Abort a run that hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Check every strobed result
    always @(posedge clk)
    begin
        if (rst_n && result_valid === 1'b1)
            sb.check_result(result);
    end

    // Drop start for a random gap once the current burst is used up
    task automatic pace();
        int gap;
        if (burst_left == 0)
        begin
            gap        = $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 10);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        burst_left--;
    endtask

    // Offer one request and hold it until the engine takes it
    task automatic send_item(input logic signed [KEY_W-1:0] key,
                             input logic [HANDLE_W-1:0] hnd, input logic last);
        hse_pkg::item_t req;
        logic           taken;
        req.sort_key  = key;
        req.handle    = hnd;
        req.last_item = last;
        pace();
        item  <= req;
        start <= 1'b1;
        // Sample busy mid-cycle so the accepting edge is the one that follows
        forever
        begin
            @(negedge clk);
            taken = (busy === 1'b0);
            @(posedge clk);
            if (taken)
                break;
        end
        sb.note_request(req);
        items_sent++;
    endtask

    function automatic logic signed [KEY_W-1:0] pick_key(key_mix_t mix);
        logic signed [KEY_W-1:0] k;
        case (mix)
            KEYS_TIED: k = KEY_W'(int'($urandom_range(0, 4)) - 2);
            KEYS_EDGE:
            begin
                case ($urandom_range(0, 3))
                    0:       k = -128;
                    1:       k = -1;
                    2:       k = 0;
                    default: k = 127;
                endcase
            end
            default:   k = KEY_W'($urandom_range(0, 255));
        endcase
        return k;
    endfunction

    // Send a set of random requests, the final one marked last
    task automatic send_set(int size);
        key_mix_t mix;
        mix = key_mix_t'($urandom_range(0, 2));
        for (int k = 0; k < size; k++)
            send_item(pick_key(mix), HANDLE_W'($urandom_range(0, 65535)), k == size - 1);
    endtask

    initial
    begin
        logic signed [KEY_W-1:0] mixed_keys[6];
        int size;
        mixed_keys = '{127, -128, 0, -1, 127, 0};
        sb    = new();
        rst_n = 1'b0;
        start = 1'b0;
        item  = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-item runs at both key extremes
        send_item(-128, 16'hFFFF, 1'b1);
        send_item(127, 16'h0000, 1'b1);
        // Extremes mixed with ties
        for (int k = 0; k < 6; k++)
            send_item(mixed_keys[k], HANDLE_W'(16'h1000 + k), k == 5);
        // Already sorted, then reversed
        for (int k = 0; k < 4; k++)
            send_item(KEY_W'(-8 + 4 * k), HANDLE_W'(16'h2000 + k), k == 3);
        for (int k = 0; k < 4; k++)
            send_item(KEY_W'(8 - 4 * k), HANDLE_W'(16'h3000 + k), k == 3);

        // Overfill the store so the last three requests are dropped
        send_set(CAPACITY + 3);
        // Mostly short sets, now and then one near or past capacity
        while (items_sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 7) == 0)
                size = $urandom_range(CAPACITY - 4, CAPACITY + 6);
            else
                size = $urandom_range(1, 12);
            send_set(size);
        end
        start <= 1'b0;

        // Drain the last run, then allow for the clearing cycle
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
